// ===== rtl/core/lkv_cache_pkg.sv =====
// Shared constants, types and helpers for the LRU key-value cache.
package lkv_cache_pkg;

  // Store geometry.
  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  // Port widths fixed by the interface.
  localparam int PORT_W = 32;
  localparam int CAP_W  = 5;

  // Cell index, fill count and compare widths.
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Operation codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic             upd;  // move the chain this cycle
    logic [IDX_W-1:0] lim;  // last cell that takes its neighbor's contents
  } lkv_ctl_t;

  // Sign-extend a port key and keep the low KEY_WIDTH bits.
  function automatic logic [KEY_WIDTH-1:0] to_key(input logic [PORT_W-1:0] k);
    logic signed [63:0] ext;
    ext = 64'($signed(k));
    return ext[KEY_WIDTH-1:0];
  endfunction

  // Sign-extend a port value and keep the low VALUE_WIDTH bits.
  function automatic logic [VALUE_WIDTH-1:0] to_value(input logic [PORT_W-1:0] v);
    logic signed [63:0] ext;
    ext = 64'($signed(v));
    return ext[VALUE_WIDTH-1:0];
  endfunction

  // Sign-extend a stored value from VALUE_WIDTH and return the port width.
  function automatic logic [PORT_W-1:0] from_value(input logic [VALUE_WIDTH-1:0] v);
    logic signed [63:0] ext;
    ext = 64'($signed(v));
    return ext[PORT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lkv_cell.sv =====
// One recency-ordered entry of the cache chain with its own key compare.
module lkv_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [lkv_cache_pkg::IDX_W-1:0]        cell_idx,
  input  lkv_cache_pkg::lkv_ctl_t                ctl,
  input  logic [lkv_cache_pkg::KEY_WIDTH-1:0]    cmp_key,
  input  logic [lkv_cache_pkg::KEY_WIDTH-1:0]    prev_key,
  input  logic [lkv_cache_pkg::VALUE_WIDTH-1:0]  prev_value,
  input  logic                                   prev_valid,
  output logic [lkv_cache_pkg::KEY_WIDTH-1:0]    key,
  output logic [lkv_cache_pkg::VALUE_WIDTH-1:0]  value,
  output logic                                   valid,
  output logic                                   match
);

  logic [lkv_cache_pkg::KEY_WIDTH-1:0]   key_r;
  logic [lkv_cache_pkg::VALUE_WIDTH-1:0] value_r;
  logic                                  valid_r;
  logic                                  take;

  // This cell moves when it lies at or before the shift limit.
  assign take = ctl.upd && (cell_idx <= ctl.lim);

  // Valid bit: the chain is empty after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= prev_valid;
    end
  end

  // Key and value payload follow the valid bit.
  always_ff @(posedge clk) begin
    if (take) begin
      key_r   <= prev_key;
      value_r <= prev_value;
    end
  end

  // Associative compare against the broadcast key.
  assign match = valid_r && (key_r == cmp_key);
  assign key   = key_r;
  assign value = value_r;
  assign valid = valid_r;

endmodule

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// Top level of the fully associative LRU key-value cache built as a chain of cells.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+-------------------------
//   command  | in_cmd, in_lookup_key, in_write_value        | start high, busy low
//   result   | out_hit, out_read_value, out_evicted         | out_valid, one cycle
//   config   | cfg_wr_data (capacity)                       | cfg_wr_en, no wait
//
// A transaction latches the command on acceptance; busy is then high while every
// cell compares its key and the chain shifts by one position. The result strobe
// follows in the next cycle, while a new command may already be accepted.
// Cell 0 holds the most recent entry.
// Reset is synchronous and empties the chain; the capacity returns to 16.
// The receiver cannot stall the result, so no transaction ever waits on it.
module lru_key_value_cache_unit (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     in_cmd,
  input  logic signed [lkv_cache_pkg::PORT_W-1:0]  in_lookup_key,
  input  logic signed [lkv_cache_pkg::PORT_W-1:0]  in_write_value,
  input  logic                                     cfg_wr_en,
  input  logic [lkv_cache_pkg::CAP_W-1:0]          cfg_wr_data,
  output logic                                     out_valid,
  output logic                                     out_hit,
  output logic signed [lkv_cache_pkg::PORT_W-1:0]  out_read_value,
  output logic                                     out_evicted
);

  localparam int N = lkv_cache_pkg::ENTRIES;

  // Control and configuration registers.
  logic                                busy_r;
  logic [lkv_cache_pkg::CAP_W-1:0]     cap_r;
  logic [lkv_cache_pkg::CNT_W-1:0]     used_r;
  logic [lkv_cache_pkg::CNT_W-1:0]     used_nxt;

  // Latched command.
  logic                                  op_cmd_r;
  logic [lkv_cache_pkg::KEY_WIDTH-1:0]   op_key_r;
  logic [lkv_cache_pkg::VALUE_WIDTH-1:0] op_value_r;

  // Result registers.
  logic                              out_valid_r;
  logic                              out_hit_r;
  logic [lkv_cache_pkg::PORT_W-1:0]  out_read_value_r;
  logic                              out_evicted_r;
  logic [lkv_cache_pkg::PORT_W-1:0]  read_nxt;
  logic                              evict_nxt;

  // Chain wiring.
  logic [lkv_cache_pkg::KEY_WIDTH-1:0]   cell_key   [N];
  logic [lkv_cache_pkg::VALUE_WIDTH-1:0] cell_value [N];
  logic [N-1:0]                          cell_valid;
  logic [N-1:0]                          cell_match;

  // Head of the chain and decode of the match vector.
  logic [lkv_cache_pkg::VALUE_WIDTH-1:0] head_value;
  logic [lkv_cache_pkg::VALUE_WIDTH-1:0] hit_value;
  logic [lkv_cache_pkg::IDX_W-1:0]       hit_idx;
  logic                                  any_hit;
  logic [lkv_cache_pkg::CMP_W-1:0]       eff_cap;
  logic [lkv_cache_pkg::CMP_W-1:0]       used_ext;
  logic                                  full;
  lkv_cache_pkg::lkv_ctl_t               ctl;

  logic accept;
  assign accept = start && !busy_r;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_cache_pkg::CAP_W'(16);
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Latch the command on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd_r   <= in_cmd;
      op_key_r   <= lkv_cache_pkg::to_key(in_lookup_key);
      op_value_r <= lkv_cache_pkg::to_value(in_write_value);
    end
  end

  // Reduce the one-hot match vector to an index and a value.
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      if (cell_match[i]) begin
        hit_idx   = hit_idx | lkv_cache_pkg::IDX_W'(i);
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  assign any_hit = |cell_match;

  // Effective capacity is clamped to the range one to ENTRIES.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lkv_cache_pkg::CMP_W'(1);
    end else if (lkv_cache_pkg::CMP_W'(cap_r) > lkv_cache_pkg::CMP_W'(N)) begin
      eff_cap = lkv_cache_pkg::CMP_W'(N);
    end else begin
      eff_cap = lkv_cache_pkg::CMP_W'(cap_r);
    end
  end

  assign used_ext = lkv_cache_pkg::CMP_W'(used_r);
  assign full     = used_ext >= eff_cap;

  // Decide how far the chain shifts and what the transaction reports.
  always_comb begin
    ctl.upd    = 1'b0;
    ctl.lim    = '0;
    used_nxt   = used_r;
    evict_nxt  = 1'b0;
    read_nxt   = '0;
    head_value = op_value_r;
    if (busy_r) begin
      if (any_hit) begin
        // Hit: the entry moves to the head, the ones before it move down.
        ctl.upd = 1'b1;
        ctl.lim = hit_idx;
        if (op_cmd_r == lkv_cache_pkg::CMD_GET) begin
          head_value = hit_value;
          read_nxt   = lkv_cache_pkg::from_value(hit_value);
        end
      end else if (op_cmd_r == lkv_cache_pkg::CMD_GET) begin
        read_nxt = '1;
      end else if (full) begin
        // Insert over the least recent entry, which drops off the tail.
        ctl.upd   = 1'b1;
        ctl.lim   = lkv_cache_pkg::IDX_W'(used_r - lkv_cache_pkg::CNT_W'(1));
        evict_nxt = 1'b1;
      end else begin
        // Insert at the head; the chain grows into the first empty cell past the tail.
        ctl.upd  = 1'b1;
        ctl.lim  = lkv_cache_pkg::IDX_W'(used_r);
        used_nxt = used_r + lkv_cache_pkg::CNT_W'(1);
      end
    end
  end

  // Cell chain: cell 0 takes the head entry, every other cell its neighbor.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [lkv_cache_pkg::KEY_WIDTH-1:0]   pk;
    logic [lkv_cache_pkg::VALUE_WIDTH-1:0] pv;
    logic                                  pval;
    if (g == 0) begin : g_head
      assign pk   = op_key_r;
      assign pv   = head_value;
      assign pval = 1'b1;
    end else begin : g_link
      assign pk   = cell_key[g-1];
      assign pv   = cell_value[g-1];
      assign pval = cell_valid[g-1];
    end
    lkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (lkv_cache_pkg::IDX_W'(g)),
      .ctl        (ctl),
      .cmp_key    (op_key_r),
      .prev_key   (pk),
      .prev_value (pv),
      .prev_valid (pval),
      .key        (cell_key[g]),
      .value      (cell_value[g]),
      .valid      (cell_valid[g]),
      .match      (cell_match[g])
    );
  end

  // Sequencing and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      used_r      <= used_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_hit_r        <= any_hit;
      out_read_value_r <= read_nxt;
      out_evicted_r    <= evict_nxt;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_evicted    = out_evicted_r;

`ifndef SYNTHESIS
  // A result strobe always follows a compare cycle.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy_r))
    else $error("result strobe without a preceding compare cycle");

  // Keys in the chain are unique, so at most one cell matches.
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot0(cell_match))
    else $error("more than one cell matched the key");

  // The fill count equals the number of valid cells.
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(used_r))
    else $error("fill count differs from valid cells");

  // An eviction only happens on an insert that missed.
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evicted_r |-> !out_hit_r)
    else $error("eviction reported together with a hit");
`endif

endmodule
